>>> rtl/pss_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pss_pkg
// Types, register codes and sine table for the primitive surface point sampler.
// ============================================================================
package pss_pkg;

    localparam int PW = 18;
    localparam int MW = 35;
    localparam int OW = 20;

    localparam logic [2:0] REG_SHAPE_KIND    = 3'd0;
    localparam logic [2:0] REG_SIZE_FIRST    = 3'd1;
    localparam logic [2:0] REG_SIZE_SECOND   = 3'd2;
    localparam logic [2:0] REG_SIZE_THIRD    = 3'd3;
    localparam logic [2:0] REG_ROTATION_QUAT = 3'd4;
    localparam logic [2:0] REG_OFFSET_XYZ    = 3'd5;

    localparam logic [1:0] SHAPE_CYLINDER = 2'd0;
    localparam logic [1:0] SHAPE_SPHERE   = 2'd1;
    localparam logic [1:0] SHAPE_BOX      = 2'd2;

    localparam logic [63:0] QUAT_IDENTITY = 64'h4000_0000_0000_0000;

    typedef struct packed {
        logic [4:0] index_a;
        logic [3:0] index_b;
    } in_t;

    typedef struct packed {
        logic signed [OW-1:0] point_x;
        logic signed [OW-1:0] point_y;
        logic signed [OW-1:0] point_z;
        logic                 index_bad;
    } out_t;

    typedef logic signed [MW-1:0] mel_t;
    typedef mel_t [8:0] mat_t;

    function automatic logic [14:0] quarter_sine(input logic [6:0] k);
        logic [14:0] s;
        case (k)
            7'd0: s = 15'd0;        7'd1: s = 15'd402;      7'd2: s = 15'd804;
            7'd3: s = 15'd1205;     7'd4: s = 15'd1606;     7'd5: s = 15'd2006;
            7'd6: s = 15'd2404;     7'd7: s = 15'd2801;     7'd8: s = 15'd3196;
            7'd9: s = 15'd3590;     7'd10: s = 15'd3981;    7'd11: s = 15'd4370;
            7'd12: s = 15'd4756;    7'd13: s = 15'd5139;    7'd14: s = 15'd5520;
            7'd15: s = 15'd5897;    7'd16: s = 15'd6270;    7'd17: s = 15'd6639;
            7'd18: s = 15'd7005;    7'd19: s = 15'd7366;    7'd20: s = 15'd7723;
            7'd21: s = 15'd8076;    7'd22: s = 15'd8423;    7'd23: s = 15'd8765;
            7'd24: s = 15'd9102;    7'd25: s = 15'd9434;    7'd26: s = 15'd9760;
            7'd27: s = 15'd10080;   7'd28: s = 15'd10394;   7'd29: s = 15'd10702;
            7'd30: s = 15'd11003;   7'd31: s = 15'd11297;   7'd32: s = 15'd11585;
            7'd33: s = 15'd11866;   7'd34: s = 15'd12140;   7'd35: s = 15'd12406;
            7'd36: s = 15'd12665;   7'd37: s = 15'd12916;   7'd38: s = 15'd13160;
            7'd39: s = 15'd13395;   7'd40: s = 15'd13623;   7'd41: s = 15'd13842;
            7'd42: s = 15'd14053;   7'd43: s = 15'd14256;   7'd44: s = 15'd14449;
            7'd45: s = 15'd14635;   7'd46: s = 15'd14811;   7'd47: s = 15'd14978;
            7'd48: s = 15'd15137;   7'd49: s = 15'd15286;   7'd50: s = 15'd15426;
            7'd51: s = 15'd15557;   7'd52: s = 15'd15679;   7'd53: s = 15'd15791;
            7'd54: s = 15'd15893;   7'd55: s = 15'd15986;   7'd56: s = 15'd16069;
            7'd57: s = 15'd16143;   7'd58: s = 15'd16207;   7'd59: s = 15'd16261;
            7'd60: s = 15'd16305;   7'd61: s = 15'd16340;   7'd62: s = 15'd16364;
            7'd63: s = 15'd16379;   7'd64: s = 15'd16384;
            default: s = 15'd0;
        endcase
        return s;
    endfunction

    function automatic logic signed [15:0] sine_of(input logic [7:0] ph);
        logic [6:0]  r;
        logic [6:0]  rr;
        logic [15:0] a;
        logic [15:0] b;
        r  = {1'b0, ph[5:0]};
        rr = 7'd64 - r;
        a  = {1'b0, quarter_sine(r)};
        b  = {1'b0, quarter_sine(rr)};
        case (ph[7:6])
            2'd0: return signed'(a);
            2'd1: return signed'(b);
            2'd2: return -signed'(a);
            default: return -signed'(b);
        endcase
    endfunction

    function automatic logic signed [15:0] cosine_of(input logic [7:0] ph);
        return sine_of(ph + 8'd64);
    endfunction

    function automatic logic signed [16:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] s;
        s = 17'(v);
        return v[15] ? -s : s;
    endfunction

    // round to nearest, halves away from zero
    function automatic logic signed [55:0] round_shift(input logic signed [55:0] v,
                                                       input int n);
        logic [55:0] mag;
        logic [55:0] r;
        mag = v[55] ? 56'(-v) : 56'(v);
        r   = (mag + (56'd1 << (n - 1))) >> n;
        return v[55] ? -signed'(r) : signed'(r);
    endfunction

endpackage

>>> rtl/pss_quat_matrix.sv
`timescale 1ns / 1ps
// ============================================================================
// pss_quat_matrix
// Rotation matrix in Q.28 from a Q1.14 quaternion, two register stages.
// ============================================================================
module pss_quat_matrix
(
    input  logic          clk,
    input  logic [63:0]   quat,
    output pss_pkg::mat_t mat
);
    import pss_pkg::*;

    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] wx_reg, wy_reg, wz_reg;
    mat_t               mat_reg;
    mat_t               mat_next;
    mel_t               one;

    assign qw  = signed'(quat[63:48]);
    assign qx  = signed'(quat[47:32]);
    assign qy  = signed'(quat[31:16]);
    assign qz  = signed'(quat[15:0]);
    assign one = MW'(1) <<< 28;

    always_ff @(posedge clk)
    begin
        xx_reg <= qx * qx;
        yy_reg <= qy * qy;
        zz_reg <= qz * qz;
        xy_reg <= qx * qy;
        xz_reg <= qx * qz;
        yz_reg <= qy * qz;
        wx_reg <= qw * qx;
        wy_reg <= qw * qy;
        wz_reg <= qw * qz;
        mat_reg <= mat_next;
    end

    always_comb
    begin
        mat_next[0] = one - ((MW'(yy_reg) + MW'(zz_reg)) <<< 1);
        mat_next[1] = (MW'(xy_reg) - MW'(wz_reg)) <<< 1;
        mat_next[2] = (MW'(xz_reg) + MW'(wy_reg)) <<< 1;
        mat_next[3] = (MW'(xy_reg) + MW'(wz_reg)) <<< 1;
        mat_next[4] = one - ((MW'(xx_reg) + MW'(zz_reg)) <<< 1);
        mat_next[5] = (MW'(yz_reg) - MW'(wx_reg)) <<< 1;
        mat_next[6] = (MW'(xz_reg) - MW'(wy_reg)) <<< 1;
        mat_next[7] = (MW'(yz_reg) + MW'(wx_reg)) <<< 1;
        mat_next[8] = one - ((MW'(xx_reg) + MW'(yy_reg)) <<< 1);
    end

    assign mat = mat_reg;

endmodule

>>> rtl/primitive_surface_point_sampler.sv
`timescale 1ns / 1ps
// throughput: one beat per cycle while out_stall is low,
// seven register stages each with its own valid
// a stage holds its beat while the next is full and stalled
// the rotation matrix follows quaternion writes via the product and matrix registers
// reset clears valids and restores registers to their reset values (identity rotation)
// ============================================================================
// primitive_surface_point_sampler
// Samples a point on a cylinder, sphere or box surface, rotates it by a
// quaternion, adds an offset and saturates to Q11.8.
// ============================================================================
module primitive_surface_point_sampler
#(
    parameter int RING_STEPS   = 32,
    parameter int SPHERE_STEPS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  pss_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output pss_pkg::out_t  out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [63:0]    cfg_data
);
    import pss_pkg::*;

    localparam int NS = 7;

    logic [1:0]  shape_kind_reg;
    logic [15:0] size_first_reg, size_second_reg, size_third_reg;
    logic [63:0] rotation_quat_reg;
    logic [47:0] offset_xyz_reg;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] rdy;

    logic [7:0] ring_ph [32];
    logic [7:0] sa_ph   [32];
    logic [7:0] sb_ph   [16];

    logic signed [16:0] r_abs, len_abs, hz_abs;
    mat_t               mat;

    // stage 1
    logic signed [15:0] sa1_reg, ca1_reg, sb1_reg, cb1_reg;
    logic               bad1_reg;
    logic [1:0]         shape1_reg;
    logic [2:0]         ib1_reg;
    logic [7:0]         pha, phb;
    logic               bad_in;

    // stage 2
    logic signed [32:0] cr2_reg, sr2_reg;
    logic signed [31:0] sc2_reg, ss2_reg;
    logic               bad2_reg;
    logic [1:0]         shape2_reg;
    logic [2:0]         ib2_reg;

    // stage 3
    logic signed [32:0] cr3_reg, sr3_reg;
    logic signed [48:0] scr3_reg, ssr3_reg;
    logic               bad3_reg;
    logic [1:0]         shape3_reg;
    logic [2:0]         ib3_reg;

    // stage 4
    logic signed [PW-1:0] p4_reg [3];
    logic signed [PW-1:0] p_next [3];
    logic                 bad4_reg;

    // stage 5
    logic signed [52:0] mp5_reg [9];
    logic               bad5_reg;

    // stage 6
    logic signed [55:0] acc6_reg [3];
    logic               bad6_reg;

    // stage 7
    out_t               out_reg;
    out_t               out_next;
    logic signed [55:0] rnd [3];
    logic signed [25:0] sum [3];
    logic signed [OW-1:0] sat [3];
    logic signed [15:0] off [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_kind_reg    <= SHAPE_CYLINDER;
            size_first_reg    <= '0;
            size_second_reg   <= '0;
            size_third_reg    <= '0;
            rotation_quat_reg <= QUAT_IDENTITY;
            offset_xyz_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SHAPE_KIND:    shape_kind_reg    <= cfg_data[1:0];
                REG_SIZE_FIRST:    size_first_reg    <= cfg_data[15:0];
                REG_SIZE_SECOND:   size_second_reg   <= cfg_data[15:0];
                REG_SIZE_THIRD:    size_third_reg    <= cfg_data[15:0];
                REG_ROTATION_QUAT: rotation_quat_reg <= cfg_data;
                REG_OFFSET_XYZ:    offset_xyz_reg    <= cfg_data[47:0];
                default: ;
            endcase
        end
    end

    pss_quat_matrix u_matrix
    (
        .clk  (clk),
        .quat (rotation_quat_reg),
        .mat  (mat)
    );

    // phase tables, step * 256 / steps
    for (genvar gi = 0; gi < 32; gi++)
    begin : g_ph_a
        localparam int RPH = (gi * 256) / RING_STEPS;
        localparam int SPH = (gi * 256) / SPHERE_STEPS;
        assign ring_ph[gi] = 8'(RPH);
        assign sa_ph[gi]   = 8'(SPH);
    end
    for (genvar gj = 0; gj < 16; gj++)
    begin : g_ph_b
        localparam int BPH = (gj * 256) / SPHERE_STEPS;
        assign sb_ph[gj] = 8'(BPH);
    end

    assign r_abs   = abs16(signed'(size_first_reg));
    assign len_abs = abs16(signed'(size_second_reg));
    assign hz_abs  = abs16(signed'(size_third_reg));

    // handshake chain
    always_comb
    begin
        rdy[NS-1] = !valid_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = valid_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // stage 1: range check and table lookups
    always_comb
    begin
        pha = (shape_kind_reg == SHAPE_SPHERE) ? sa_ph[in_data.index_a]
                                               : ring_ph[in_data.index_a];
        phb = sb_ph[in_data.index_b];
        case (shape_kind_reg)
            SHAPE_CYLINDER: bad_in = {4'd0, in_data.index_a} >= 9'(RING_STEPS);
            SHAPE_SPHERE:   bad_in = ({4'd0, in_data.index_a} >= 9'(SPHERE_STEPS))
                                  || ({5'd0, in_data.index_b} >= 9'(SPHERE_STEPS));
            SHAPE_BOX:      bad_in = 1'b0;
            default:        bad_in = 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            sa1_reg    <= sine_of(pha);
            ca1_reg    <= cosine_of(pha);
            sb1_reg    <= sine_of(phb);
            cb1_reg    <= cosine_of(phb);
            bad1_reg   <= bad_in;
            shape1_reg <= shape_kind_reg;
            ib1_reg    <= in_data.index_b[2:0];
        end
    end

    // stage 2: first products
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            cr2_reg    <= ca1_reg * r_abs;
            sr2_reg    <= sa1_reg * r_abs;
            sc2_reg    <= sa1_reg * cb1_reg;
            ss2_reg    <= sa1_reg * sb1_reg;
            bad2_reg   <= bad1_reg;
            shape2_reg <= shape1_reg;
            ib2_reg    <= ib1_reg;
        end
    end

    // stage 3: sphere radius products
    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            cr3_reg    <= cr2_reg;
            sr3_reg    <= sr2_reg;
            scr3_reg   <= sc2_reg * r_abs;
            ssr3_reg   <= ss2_reg * r_abs;
            bad3_reg   <= bad2_reg;
            shape3_reg <= shape2_reg;
            ib3_reg    <= ib2_reg;
        end
    end

    // stage 4: local point
    always_comb
    begin
        case (shape3_reg)
            SHAPE_SPHERE:
            begin
                p_next[0] = PW'(round_shift(56'(scr3_reg), 27));
                p_next[1] = PW'(round_shift(56'(ssr3_reg), 27));
                p_next[2] = PW'(round_shift(56'(cr3_reg), 13));
            end
            SHAPE_BOX:
            begin
                p_next[0] = ib3_reg[2] ? PW'(r_abs)   : -PW'(r_abs);
                p_next[1] = ib3_reg[1] ? PW'(len_abs) : -PW'(len_abs);
                p_next[2] = ib3_reg[0] ? PW'(hz_abs)  : -PW'(hz_abs);
            end
            default:
            begin
                p_next[0] = PW'(round_shift(56'(cr3_reg), 13));
                p_next[1] = PW'(round_shift(56'(sr3_reg), 13));
                p_next[2] = ib3_reg[0] ? -PW'(len_abs) : PW'(len_abs);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            p4_reg   <= p_next;
            bad4_reg <= bad3_reg;
        end
    end

    // stage 5: matrix products
    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            for (int k = 0; k < 9; k++)
            begin
                mp5_reg[k] <= mat[k] * p4_reg[k % 3];
            end
            bad5_reg <= bad4_reg;
        end
    end

    // stage 6: row sums
    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            for (int k = 0; k < 3; k++)
            begin
                acc6_reg[k] <= 56'(mp5_reg[3*k]) + 56'(mp5_reg[3*k+1])
                             + 56'(mp5_reg[3*k+2]);
            end
            bad6_reg <= bad5_reg;
        end
    end

    // stage 7: round, offset, saturate, zero the point of a bad-index beat
    assign off[0] = signed'(offset_xyz_reg[47:32]);
    assign off[1] = signed'(offset_xyz_reg[31:16]);
    assign off[2] = signed'(offset_xyz_reg[15:0]);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rnd[k] = round_shift(acc6_reg[k], 29);
            sum[k] = 26'(rnd[k]) + 26'(off[k]);
            if (sum[k] > 26'sd524287)
            begin
                sat[k] = 20'sd524287;
            end
            else if (sum[k] < -26'sd524288)
            begin
                sat[k] = -20'sd524288;
            end
            else
            begin
                sat[k] = OW'(sum[k]);
            end
        end
        out_next.point_x   = bad6_reg ? '0 : sat[0];
        out_next.point_y   = bad6_reg ? '0 : sat[1];
        out_next.point_z   = bad6_reg ? '0 : sat[2];
        out_next.index_bad = bad6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.index_bad |->
            out_data.point_x == '0 && out_data.point_y == '0 && out_data.point_z == '0)
        else $error("bad index beat with nonzero point");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&valid_reg) && out_stall)
        else $error("input stalled with room in the pipeline");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> !$past(out_stall))
        else $error("output beat dropped while stalled");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NS-2] && !out_stall |=> out_valid)
        else $error("pipeline beat not advanced to output");

endmodule
